// ----- rtl/core/lec_pkg.sv -----
// Constants and character classification helpers for the license expression checker.
`default_nettype none

package lec_pkg;

  localparam int unsigned MAX_NEST = 255;
  localparam int unsigned NEST_W   = $clog2(MAX_NEST + 1);

  localparam logic [NEST_W-1:0] NEST_MAX  = NEST_W'(MAX_NEST);
  localparam logic [NEST_W-1:0] NEST_ZERO = '0;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Bit positions in the keyword match vector.
  localparam int unsigned KW_AND  = 0;
  localparam int unsigned KW_OR   = 1;
  localparam int unsigned KW_WITH = 2;

  localparam logic [2:0] LEN_OR   = 3'd2;
  localparam logic [2:0] LEN_AND  = 3'd3;
  localparam logic [2:0] LEN_WITH = 3'd4;
  localparam logic [2:0] LEN_SAT  = 3'd7;

  function automatic logic id_char(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_DOT) || (c == CH_MINUS);
  endfunction

  // For each keyword, whether character c matches that keyword at position pos.
  function automatic logic [2:0] kw_hit(input logic [2:0] pos, input logic [7:0] c);
    logic [2:0] hit;
    hit = '0;
    case (pos)
      3'd0: begin
        hit[KW_AND]  = (c == 8'h41);
        hit[KW_OR]   = (c == 8'h4F);
        hit[KW_WITH] = (c == 8'h57);
      end
      3'd1: begin
        hit[KW_AND]  = (c == 8'h4E);
        hit[KW_OR]   = (c == 8'h52);
        hit[KW_WITH] = (c == 8'h49);
      end
      3'd2: begin
        hit[KW_AND]  = (c == 8'h44);
        hit[KW_WITH] = (c == 8'h54);
      end
      3'd3: begin
        hit[KW_WITH] = (c == 8'h48);
      end
      default: hit = '0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/license_expression_checker_top.sv -----
// License expression checker: character stream in, one verdict per expression out.
//
//   Channel   Dir  tdata (low bit up)     tlast               Use
//   s_axis    in   ch[7:0]                end_mark            one character per request
//   m_axis    out  valid_res, 7'b0        -                   verdict on each end_mark
//
// One character per cycle but for stalls. A request passes the input register
// and token logic; the verdict is registered as the end marker leaves the input
// register. Synchronous reset returns the parser to its idle state. Characters
// keep flowing while a verdict waits; only a second end marker stalls behind an
// untaken verdict, which is the one case that drops s_axis_tready.
`default_nettype none

module license_expression_checker_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] ch
  input  wire logic       s_axis_tlast,   // end_mark
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [0] valid_res, [7:1] zero
);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_ch;
  logic       s1_end;
  logic       s1_adv;

  // Parser state.
  logic                      want_operand, want_operand_next;
  logic [lec_pkg::NEST_W-1:0] nest_level, nest_level_next;
  logic                      failed, failed_next;
  logic                      in_word, in_word_next;
  logic [2:0]                word_len, word_len_next;
  logic [2:0]                keyword_match, keyword_match_next;
  logic                      chars_ok, chars_ok_next;
  logic                      prev_plus, prev_plus_next;

  logic out_valid;
  logic out_res, out_res_next;

  // Token logic intermediates.
  logic       is_delim, is_lpar, is_rpar, is_word;
  logic       finish, fw_kw, fw_id;
  logic       wo1, fail1;
  logic [2:0] pos;
  logic [2:0] km_base;
  logic       ok_base, pp_base;

  assign s1_adv        = !s1_end || !out_valid || m_axis_tready;
  assign s_axis_tready = !s1_valid || s1_adv;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_res};

  always_comb begin
    is_lpar  = (s1_ch == lec_pkg::CH_LPAR);
    is_rpar  = (s1_ch == lec_pkg::CH_RPAR);
    is_delim = (s1_ch == lec_pkg::CH_SPACE) || (s1_ch == lec_pkg::CH_TAB) ||
               is_lpar || is_rpar;
    is_word  = !s1_end && !is_delim;

    // Judge a pending word when a delimiter or the end marker arrives.
    finish = in_word && !is_word;
    fw_kw  = (keyword_match[lec_pkg::KW_AND]  && (word_len == lec_pkg::LEN_AND)) ||
             (keyword_match[lec_pkg::KW_OR]   && (word_len == lec_pkg::LEN_OR)) ||
             (keyword_match[lec_pkg::KW_WITH] && (word_len == lec_pkg::LEN_WITH));
    fw_id  = chars_ok && !((word_len == 3'd1) && prev_plus);
    wo1    = finish ? fw_kw : want_operand;
    fail1  = failed || (finish && (fw_kw ? want_operand : (!want_operand || !fw_id)));

    pos     = in_word ? word_len : 3'd0;
    km_base = in_word ? keyword_match : 3'b111;
    ok_base = in_word ? chars_ok : 1'b1;
    pp_base = in_word && prev_plus;

    want_operand_next  = wo1;
    nest_level_next    = nest_level;
    failed_next        = fail1;
    in_word_next       = 1'b0;
    word_len_next      = 3'd0;
    keyword_match_next = 3'd0;
    chars_ok_next      = 1'b1;
    prev_plus_next     = 1'b0;
    out_res_next       = !fail1 && !wo1 && (nest_level == lec_pkg::NEST_ZERO);

    if (s1_end) begin
      want_operand_next = 1'b1;
      nest_level_next   = lec_pkg::NEST_ZERO;
      failed_next       = 1'b0;
    end else if (is_lpar) begin
      if (!wo1 || (nest_level == lec_pkg::NEST_MAX)) begin
        failed_next = 1'b1;
      end else begin
        nest_level_next = nest_level + 1'b1;
      end
    end else if (is_rpar) begin
      if (wo1 || (nest_level == lec_pkg::NEST_ZERO)) begin
        failed_next = 1'b1;
      end else begin
        nest_level_next = nest_level - 1'b1;
      end
    end else if (is_word) begin
      in_word_next       = 1'b1;
      word_len_next      = (pos < lec_pkg::LEN_SAT) ? pos + 3'd1 : lec_pkg::LEN_SAT;
      keyword_match_next = km_base & lec_pkg::kw_hit(pos, s1_ch);
      chars_ok_next      = ok_base && !pp_base &&
                           ((s1_ch == lec_pkg::CH_PLUS) || lec_pkg::id_char(s1_ch));
      prev_plus_next     = (s1_ch == lec_pkg::CH_PLUS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      want_operand  <= 1'b1;
      nest_level    <= lec_pkg::NEST_ZERO;
      failed        <= 1'b0;
      in_word       <= 1'b0;
      word_len      <= 3'd0;
      keyword_match <= 3'd0;
      chars_ok      <= 1'b1;
      prev_plus     <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      // A new verdict replaces one that is taken in the same cycle.
      if (s1_valid && s1_adv && s1_end) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (s1_valid && s1_adv) begin
        want_operand  <= want_operand_next;
        nest_level    <= nest_level_next;
        failed        <= failed_next;
        in_word       <= in_word_next;
        word_len      <= word_len_next;
        keyword_match <= keyword_match_next;
        chars_ok      <= chars_ok_next;
        prev_plus     <= prev_plus_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_ch  <= s_axis_tdata;
      s1_end <= s_axis_tlast;
    end
    if (s1_valid && s1_adv && s1_end) begin
      out_res <= out_res_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lec_checker.sv -----
// Port-level assertions for the license expression checker, bound to the top level.
`default_nettype none

module lec_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  // A verdict held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("verdict changed while stalled");

  // Only the low bit of the verdict carries information.
  a_out_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'b0))
    else $error("verdict padding bits not zero");

  // Input backpressure only comes from an untaken verdict.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a pending verdict");

  // Reset leaves no verdict behind.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("verdict present after reset");

endmodule

bind license_expression_checker_top lec_checker u_lec_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
